[src/sbpd_pkg.sv]
// Package for the servo bus packet deframer: payload structs, phase enum,
// byte role codes and header byte constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbpd_pkg;

  localparam logic [7:0] HDR_FF = 8'hFF;
  localparam logic [7:0] HDR_FD = 8'hFD;

  localparam logic [2:0] ROLE_DROP     = 3'd0;
  localparam logic [2:0] ROLE_HEADER   = 3'd1;
  localparam logic [2:0] ROLE_RESERVED = 3'd2;
  localparam logic [2:0] ROLE_ID       = 3'd3;
  localparam logic [2:0] ROLE_LEN_LO   = 3'd4;
  localparam logic [2:0] ROLE_LEN_HI   = 3'd5;
  localparam logic [2:0] ROLE_BODY     = 3'd6;

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_HUNT2 = 3'd2,
    PH_RSVD  = 3'd3,
    PH_ID    = 3'd4,
    PH_LENL  = 3'd5,
    PH_LENH  = 3'd6,
    PH_BODY  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_role;
    logic        resync;
    logic        packet_done;
    logic        truncated;
    logic [7:0]  packet_id;
    logic [15:0] packet_length;
    logic [15:0] body_index;
  } out_item_t;

endpackage

`default_nettype wire

[src/servo_bus_packet_deframer_unit.sv]
// Servo bus packet deframer top level: header hunt, ID/length capture, body count.
// A result is registered in the output register, or in the skid entry while the output holds one.
// Throughput: one item per cycle while the skid entry is empty; an output register plus a skid
// entry keep input acceptance going while one result waits on the output.
// Reset: asynchronous, active low; phase returns to hunting, all holds clear.
// Depends on sbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module servo_bus_packet_deframer_unit
  import sbpd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  id_q, id_d;

  out_item_t   res;
  out_item_t   out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        accept, pop;
  logic [15:0] new_len;
  logic [16:0] count_inc;

  assign in_ready_o  = ~skid_valid_q;
  assign accept      = in_valid_i & in_ready_o;
  assign pop         = out_valid_q & out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign new_len   = {in_data_i.rx_byte, len_lo_q};
  assign count_inc = {1'b0, count_q} + 17'd1;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    len_lo_d = len_lo_q;
    count_d  = count_q;
    id_d     = id_q;
    case (phase_q)
      PH_HUNT0: phase_d = (in_data_i.rx_byte == HDR_FF) ? PH_HUNT1 : PH_HUNT0;
      PH_HUNT1: phase_d = (in_data_i.rx_byte == HDR_FF) ? PH_HUNT2 : PH_HUNT0;
      PH_HUNT2: phase_d = (in_data_i.rx_byte == HDR_FD) ? PH_RSVD : PH_HUNT0;
      PH_RSVD:  phase_d = PH_ID;
      PH_ID: begin
        id_d    = in_data_i.rx_byte;
        phase_d = PH_LENL;
      end
      PH_LENL: begin
        len_lo_d = in_data_i.rx_byte;
        phase_d  = PH_LENH;
      end
      PH_LENH: begin
        length_d = new_len;
        count_d  = '0;
        phase_d  = (new_len == 16'd0) ? PH_HUNT0 : PH_BODY;
      end
      PH_BODY: begin
        if (count_inc >= {1'b0, length_q}) begin
          count_d = '0;
          phase_d = PH_HUNT0;
        end else begin
          count_d = count_inc[15:0];
        end
      end
      default: phase_d = PH_HUNT0;
    endcase
    // buffer end drops any partial packet
    if (in_data_i.buffer_end) begin
      phase_d  = PH_HUNT0;
      length_d = '0;
      len_lo_d = '0;
      count_d  = '0;
      id_d     = '0;
    end
  end

  // Result fields
  always_comb begin
    res               = '0;
    res.byte_value    = in_data_i.rx_byte;
    res.byte_role     = ROLE_DROP;
    case (phase_q)
      PH_HUNT0, PH_HUNT1: begin
        if (in_data_i.rx_byte == HDR_FF) res.byte_role = ROLE_HEADER;
        else                             res.resync    = 1'b1;
      end
      PH_HUNT2: begin
        if (in_data_i.rx_byte == HDR_FD) res.byte_role = ROLE_HEADER;
        else                             res.resync    = 1'b1;
      end
      PH_RSVD: res.byte_role = ROLE_RESERVED;
      PH_ID: begin
        res.byte_role = ROLE_ID;
        res.packet_id = in_data_i.rx_byte;
      end
      PH_LENL: begin
        res.byte_role = ROLE_LEN_LO;
        res.packet_id = id_q;
      end
      PH_LENH: begin
        res.byte_role     = ROLE_LEN_HI;
        res.packet_id     = id_q;
        res.packet_length = new_len;
        res.packet_done   = (new_len == 16'd0);
      end
      PH_BODY: begin
        res.byte_role     = ROLE_BODY;
        res.packet_id     = id_q;
        res.packet_length = length_q;
        res.body_index    = count_q;
        res.packet_done   = (count_inc >= {1'b0, length_q});
      end
      default: res.byte_role = ROLE_DROP;
    endcase
    // phase after this byte, before the buffer-end clear
    res.truncated = in_data_i.buffer_end & ~(res.packet_done | res.resync |
                    (phase_q == PH_HUNT0 && in_data_i.rx_byte != HDR_FF));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT0;
      length_q <= '0;
      len_lo_q <= '0;
      count_q  <= '0;
      id_q     <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      len_lo_q <= len_lo_d;
      count_q  <= count_d;
      id_q     <= id_d;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (!out_valid_q || pop) out_valid_q  <= 1'b1;
      else                     skid_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (accept) begin
      if (!out_valid_q || pop) out_q  <= res;
      else                     skid_q <= res;
    end
  end

endmodule

`default_nettype wire

[src/sbpd_checker.sv]
// Port-level checker for the servo bus packet deframer, bound to the top level.
// Depends on sbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpd_checker
  import sbpd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.packet_done |->
      out_data_o.byte_role == ROLE_LEN_HI || out_data_o.byte_role == ROLE_BODY)
    else $error("packet end on a non-length, non-body item");

  a_resync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.resync |->
      out_data_o.byte_role == ROLE_DROP && !out_data_o.truncated)
    else $error("resync on a kept item");

  a_done_not_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.packet_done && out_data_o.truncated))
    else $error("item both completes and truncates a packet");

  a_index_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_role != ROLE_BODY |-> out_data_o.body_index == 16'd0)
    else $error("body index outside the body");

endmodule

bind servo_bus_packet_deframer_unit sbpd_checker u_sbpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
